@@ design/agu_pkg.sv @@
// ============================================================================
// agu_pkg - shared types and constants for the activation gradient unit
// Widths, mode and operation codes, and the command word passed from the
// front end to the back end.
// ============================================================================
package agu_pkg;

   // Sizing
   localparam int MAX_ROW     = 64;
   localparam int FRAC_BITS   = 12;
   localparam int SLOPE_FRAC  = 12;
   localparam int DATA_W      = 16;
   localparam int ADDR_W      = $clog2(MAX_ROW);
   localparam int CNT_W       = $clog2(MAX_ROW + 1);
   localparam int DOT_W       = 40;
   localparam int MODE_W      = 3;
   localparam int SLOPE_W     = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int RAM_W       = 2 * DATA_W;

   // Multiplier split: B operand is cut into a signed high part and an
   // unsigned low part so no single product exceeds ~16x22 bits.
   localparam int B_W         = DOT_W + 1;
   localparam int LO_W        = 21;
   localparam int HI_W        = B_W - LO_W;
   localparam int P_W         = DATA_W + B_W;
   localparam int R_W         = P_W + 1;

   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   // Arithmetic constants
   localparam logic signed [DATA_W+1:0] ONE_EXT  = (DATA_W + 2)'(2 ** FRAC_BITS);
   localparam logic signed [B_W-1:0]    ONE_SQ_B = B_W'(2 ** (2 * FRAC_BITS));
   localparam logic signed [R_W-1:0]    RND_SLOPE = R_W'(2 ** (SLOPE_FRAC - 1));
   localparam logic signed [R_W-1:0]    RND_PROD  = R_W'(2 ** (2 * FRAC_BITS - 1));
   localparam logic signed [R_W-1:0]    SAT_MAX   = R_W'(2 ** (DATA_W - 1) - 1);
   localparam logic signed [R_W-1:0]    SAT_MIN   = -SAT_MAX - R_W'(1);
   localparam logic [SLOPE_W-1:0]       SLOPE_RESET = SLOPE_W'(41);

   typedef enum logic [MODE_W-1:0] {
      MODE_LINEAR   = 3'd0,
      MODE_LOGISTIC = 3'd1,
      MODE_TANH     = 3'd2,
      MODE_RELU     = 3'd3,
      MODE_LEAKY    = 3'd4,
      MODE_SOFTMAX  = 3'd5
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE = 2'd0,
      CSR_LEAK = 2'd1
   } csr_reg_type;

   typedef enum logic [2:0] {
      OP_PASS     = 3'd0,
      OP_ZERO     = 3'd1,
      OP_LOGISTIC = 3'd2,
      OP_TANH     = 3'd3,
      OP_LEAKY    = 3'd4,
      OP_ROW      = 3'd5,
      OP_SOFTMAX  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      SH_NONE  = 2'd0,
      SH_SLOPE = 2'd1,
      SH_PROD  = 2'd2
   } shift_type;

   typedef enum logic {
      ISSUE_CMD = 1'b0,
      ISSUE_ROW = 1'b1
   } issue_state_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  y;
      logic signed [DATA_W-1:0]  g;
      logic                      last;
      logic [CNT_W-1:0]          count;
      logic signed [DOT_W-1:0]   dot;
      logic                      ovf;
   } cmd_type;

endpackage

@@ design/agu_if.sv @@
// ============================================================================
// agu_if - channel interfaces of the activation gradient unit
// Request, response and register write channels, each valid/ready.
// ============================================================================
interface agu_req_if import agu_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] out_value;
   logic signed [DATA_W-1:0] grad_in;
   logic                     row_last;

   modport source (output valid, output out_value, output grad_in, output row_last,
                   input ready);
   modport sink   (input valid, input out_value, input grad_in, input row_last,
                   output ready);
endinterface

interface agu_rsp_if import agu_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] grad_out;
   logic                     result_last;
   logic                     saturated;

   modport source (output valid, output grad_out, output result_last, output saturated,
                   input ready);
   modport sink   (input valid, input grad_out, input result_last, input saturated,
                   output ready);
endinterface

interface agu_csr_if import agu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ design/agu_ram.sv @@
// ============================================================================
// agu_ram - simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
module agu_ram #(
   parameter int  DEPTH = 64,
   parameter int  WIDTH = 32,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/agu_cmd_fifo.sv @@
// ============================================================================
// agu_cmd_fifo - command queue between front end and back end
// Small flop-based FIFO of cmd_type words.
// ============================================================================
module agu_cmd_fifo import agu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type din,
   input  logic    pop,
   output cmd_type dout,
   output logic    full,
   output logic    empty
);

   cmd_type                entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   push_ok, pop_ok;

   assign full    = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign dout    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

@@ design/agu_front.sv @@
// ============================================================================
// agu_front - request intake, register file and softmax row buffering
// Classifies each pair by mode into a back-end command; in softmax mode
// stores the row and accumulates the dot product.
// ============================================================================
module agu_front import agu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   agu_req_if.sink            req_ch,
   agu_csr_if.sink            csr_ch,
   input  logic               fifo_full,
   output logic               fifo_push,
   output cmd_type            fifo_din,
   output logic               ram_wr_en,
   output logic [ADDR_W-1:0]  ram_wr_addr,
   output logic [RAM_W-1:0]   ram_wr_data,
   input  logic               row_done,
   output logic [SLOPE_W-1:0] leak_slope
);

   logic [MODE_W-1:0]        mode_ff, mode_in;
   logic [SLOPE_W-1:0]       slope_ff, slope_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic                     ovf_ff, ovf_in;
   logic                     row_busy_ff, row_busy_in;

   logic                     is_soft;
   logic                     accept;
   logic                     room;
   logic                     y_neg;
   logic signed [2*DATA_W-1:0] yg_prod;
   op_type                   elem_op;

   assign is_soft      = (mode_ff == MODE_SOFTMAX);
   // one row at a time in the buffer: hold softmax input while a row drains
   assign req_ch.ready = !fifo_full && !(is_soft && row_busy_ff);
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;
   assign room         = (count_ff < CNT_W'(MAX_ROW));
   assign y_neg        = req_ch.out_value[DATA_W-1];
   assign yg_prod      = req_ch.out_value * req_ch.grad_in;
   assign leak_slope   = slope_ff;

   always_comb begin
      unique case (mode_ff)
         MODE_LOGISTIC: elem_op = OP_LOGISTIC;
         MODE_TANH:     elem_op = OP_TANH;
         MODE_RELU:     elem_op = y_neg ? OP_ZERO  : OP_PASS;
         MODE_LEAKY:    elem_op = y_neg ? OP_LEAKY : OP_PASS;
         default:       elem_op = OP_PASS;
      endcase
   end

   always_comb begin
      mode_in     = mode_ff;
      slope_in    = slope_ff;
      count_in    = count_ff;
      dot_in      = dot_ff;
      ovf_in      = ovf_ff;
      row_busy_in = row_busy_ff;

      fifo_push     = 1'b0;
      fifo_din      = '0;
      fifo_din.op   = elem_op;
      fifo_din.y    = req_ch.out_value;
      fifo_din.g    = req_ch.grad_in;
      fifo_din.last = req_ch.row_last;

      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[ADDR_W-1:0];
      ram_wr_data = {req_ch.out_value, req_ch.grad_in};

      if (accept) begin
         if (is_soft) begin
            if (room) begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               dot_in    = dot_ff + DOT_W'(yg_prod);
            end else begin
               ovf_in = 1'b1;
            end
            if (req_ch.row_last) begin
               fifo_push      = 1'b1;
               fifo_din.op    = OP_ROW;
               fifo_din.count = count_in;
               fifo_din.dot   = dot_in;
               fifo_din.ovf   = ovf_in;
               count_in       = '0;
               dot_in         = '0;
               ovf_in         = 1'b0;
               row_busy_in    = 1'b1;
            end
         end else begin
            fifo_push = 1'b1;
         end
      end

      if (row_done) begin
         row_busy_in = 1'b0;
      end

      if (csr_ch.valid) begin
         unique case (csr_reg_type'(csr_ch.reg_index))
            CSR_MODE: begin
               mode_in  = csr_ch.wr_data[MODE_W-1:0];
               count_in = '0;
               dot_in   = '0;
               ovf_in   = 1'b0;
            end
            CSR_LEAK: slope_in = csr_ch.wr_data[SLOPE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_LINEAR;
         slope_ff    <= SLOPE_RESET;
         count_ff    <= '0;
         dot_ff      <= '0;
         ovf_ff      <= 1'b0;
         row_busy_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         slope_ff    <= slope_in;
         count_ff    <= count_in;
         dot_ff      <= dot_in;
         ovf_ff      <= ovf_in;
         row_busy_ff <= row_busy_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ROW))
      else $error("row count beyond buffer depth");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      row_done |-> row_busy_ff)
      else $error("row drain finished with no row outstanding");

endmodule

@@ design/agu_back.sv @@
// ============================================================================
// agu_back - command execution pipeline
// Issues commands (expanding a softmax row into per-element reads of the
// row buffer), then operand build, split multiply, sum, round and saturate.
// ============================================================================
module agu_back import agu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               fifo_empty,
   input  cmd_type            fifo_dout,
   output logic               fifo_pop,
   output logic               ram_rd_en,
   output logic [ADDR_W-1:0]  ram_rd_addr,
   input  logic [RAM_W-1:0]   ram_rd_data,
   output logic               row_done,
   input  logic [SLOPE_W-1:0] leak_slope,
   agu_rsp_if.source          rsp_ch
);

   logic adv;

   // issue sequencer
   issue_state_type          issue_state_ff, issue_state_in;
   logic [CNT_W-1:0]         row_count_ff, row_count_in;
   logic signed [DOT_W-1:0]  row_dot_ff, row_dot_in;
   logic                     row_ovf_ff, row_ovf_in;
   logic [ADDR_W-1:0]        elem_idx_ff, elem_idx_in;
   logic                     elem_last;

   // stage 0: issued element
   logic                     s0_valid_ff, s0_valid_in;
   op_type                   s0_op_ff, s0_op_in;
   logic signed [DATA_W-1:0] s0_y_ff, s0_y_in;
   logic signed [DATA_W-1:0] s0_g_ff, s0_g_in;
   logic signed [DOT_W-1:0]  s0_dot_ff, s0_dot_in;
   logic                     s0_last_ff, s0_last_in;
   logic                     s0_flag_ff, s0_flag_in;
   logic                     s0_ram_ff, s0_ram_in;

   // stage 1: operands
   logic                     s1_valid_ff;
   logic signed [DATA_W-1:0] s1_a_ff, s1_a_in;
   logic signed [B_W-1:0]    s1_b_ff, s1_b_in;
   shift_type                s1_sh_ff, s1_sh_in;
   logic                     s1_last_ff, s1_flag_ff;
   logic signed [DATA_W-1:0] y_sel, g_sel;
   logic signed [DATA_W+1:0] one_minus_y;
   logic signed [2*DATA_W+1:0] logi_prod;
   logic signed [2*DATA_W-1:0] y_sq;

   // stage 2: partial products
   logic                     s2_valid_ff;
   logic signed [DATA_W+HI_W-1:0]   s2_hi_ff, s2_hi_in;
   logic signed [DATA_W+LO_W:0]     s2_lo_ff, s2_lo_in;
   shift_type                s2_sh_ff;
   logic                     s2_last_ff, s2_flag_ff;

   // stage 3: full product
   logic                     s3_valid_ff;
   logic signed [P_W-1:0]    s3_p_ff, s3_p_in;
   shift_type                s3_sh_ff;
   logic                     s3_last_ff, s3_flag_ff;

   // output register
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_grad_ff, rsp_grad_in;
   logic                     rsp_last_ff;
   logic                     rsp_sat_ff, rsp_sat_in;
   logic signed [R_W-1:0]    p_ext, rounded;

   assign adv = !rsp_valid_ff || rsp_ch.ready;
   assign elem_last = ((CNT_W'(elem_idx_ff) + CNT_W'(1)) == row_count_ff);

   // ---------------- issue ----------------
   always_comb begin
      issue_state_in = issue_state_ff;
      row_count_in   = row_count_ff;
      row_dot_in     = row_dot_ff;
      row_ovf_in     = row_ovf_ff;
      elem_idx_in    = elem_idx_ff;
      fifo_pop       = 1'b0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = elem_idx_ff;
      row_done       = 1'b0;

      s0_valid_in = 1'b0;
      s0_op_in    = fifo_dout.op;
      s0_y_in     = fifo_dout.y;
      s0_g_in     = fifo_dout.g;
      s0_dot_in   = '0;
      s0_last_in  = fifo_dout.last;
      s0_flag_in  = 1'b0;
      s0_ram_in   = 1'b0;

      unique case (issue_state_ff)
         ISSUE_CMD: begin
            if (adv && !fifo_empty) begin
               fifo_pop = 1'b1;
               if (fifo_dout.op == OP_ROW) begin
                  issue_state_in = ISSUE_ROW;
                  row_count_in   = fifo_dout.count;
                  row_dot_in     = fifo_dout.dot;
                  row_ovf_in     = fifo_dout.ovf;
                  elem_idx_in    = '0;
               end else begin
                  s0_valid_in = 1'b1;
               end
            end
         end
         ISSUE_ROW: begin
            if (adv) begin
               ram_rd_en   = 1'b1;
               s0_valid_in = 1'b1;
               s0_op_in    = OP_SOFTMAX;
               s0_dot_in   = row_dot_ff;
               s0_last_in  = elem_last;
               s0_flag_in  = row_ovf_ff;
               s0_ram_in   = 1'b1;
               elem_idx_in = elem_idx_ff + ADDR_W'(1);
               if (elem_last) begin
                  issue_state_in = ISSUE_CMD;
                  row_done       = 1'b1;
               end
            end
         end
         default: issue_state_in = ISSUE_CMD;
      endcase
   end

   // ---------------- stage 1: operand build ----------------
   always_comb begin
      y_sel       = s0_ram_ff ? $signed(ram_rd_data[RAM_W-1:DATA_W]) : s0_y_ff;
      g_sel       = s0_ram_ff ? $signed(ram_rd_data[DATA_W-1:0])     : s0_g_ff;
      one_minus_y = ONE_EXT - (DATA_W + 2)'(y_sel);
      logi_prod   = y_sel * one_minus_y;
      y_sq        = y_sel * y_sel;

      s1_a_in  = g_sel;
      s1_b_in  = B_W'(1);
      s1_sh_in = SH_NONE;
      unique case (s0_op_ff)
         OP_ZERO: begin
            s1_a_in = '0;
         end
         OP_LOGISTIC: begin
            s1_b_in  = B_W'(logi_prod);
            s1_sh_in = SH_PROD;
         end
         OP_TANH: begin
            s1_b_in  = ONE_SQ_B - B_W'(y_sq);
            s1_sh_in = SH_PROD;
         end
         OP_LEAKY: begin
            s1_b_in  = $signed(B_W'(leak_slope));
            s1_sh_in = SH_SLOPE;
         end
         OP_SOFTMAX: begin
            s1_a_in  = y_sel;
            s1_b_in  = (B_W'(g_sel) <<< FRAC_BITS) - B_W'(s0_dot_ff);
            s1_sh_in = SH_PROD;
         end
         default: ;
      endcase
   end

   // ---------------- stage 2: split multiply ----------------
   assign s2_hi_in = s1_a_ff * $signed(s1_b_ff[B_W-1:LO_W]);
   assign s2_lo_in = s1_a_ff * $signed({1'b0, s1_b_ff[LO_W-1:0]});

   // ---------------- stage 3: recombine ----------------
   assign s3_p_in = (P_W'(s2_hi_ff) <<< LO_W) + P_W'(s2_lo_ff);

   // ---------------- stage 4: round half up, saturate ----------------
   always_comb begin
      p_ext = R_W'(s3_p_ff);
      unique case (s3_sh_ff)
         SH_SLOPE: rounded = (p_ext + RND_SLOPE) >>> SLOPE_FRAC;
         SH_PROD:  rounded = (p_ext + RND_PROD) >>> (2 * FRAC_BITS);
         default:  rounded = p_ext;
      endcase
      rsp_sat_in = s3_flag_ff;
      if (rounded > SAT_MAX) begin
         rsp_grad_in = SAT_MAX[DATA_W-1:0];
         rsp_sat_in  = 1'b1;
      end else if (rounded < SAT_MIN) begin
         rsp_grad_in = SAT_MIN[DATA_W-1:0];
         rsp_sat_in  = 1'b1;
      end else begin
         rsp_grad_in = rounded[DATA_W-1:0];
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_state_ff <= ISSUE_CMD;
         row_count_ff   <= '0;
         row_dot_ff     <= '0;
         row_ovf_ff     <= 1'b0;
         elem_idx_ff    <= '0;
         s0_valid_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         issue_state_ff <= issue_state_in;
         row_count_ff   <= row_count_in;
         row_dot_ff     <= row_dot_in;
         row_ovf_ff     <= row_ovf_in;
         elem_idx_ff    <= elem_idx_in;
         if (adv) begin
            s0_valid_ff  <= s0_valid_in;
            s1_valid_ff  <= s0_valid_ff;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_op_ff    <= s0_op_in;
         s0_y_ff     <= s0_y_in;
         s0_g_ff     <= s0_g_in;
         s0_dot_ff   <= s0_dot_in;
         s0_last_ff  <= s0_last_in;
         s0_flag_ff  <= s0_flag_in;
         s0_ram_ff   <= s0_ram_in;

         s1_a_ff     <= s1_a_in;
         s1_b_ff     <= s1_b_in;
         s1_sh_ff    <= s1_sh_in;
         s1_last_ff  <= s0_last_ff;
         s1_flag_ff  <= s0_flag_ff;

         s2_hi_ff    <= s2_hi_in;
         s2_lo_ff    <= s2_lo_in;
         s2_sh_ff    <= s1_sh_ff;
         s2_last_ff  <= s1_last_ff;
         s2_flag_ff  <= s1_flag_ff;

         s3_p_ff     <= s3_p_in;
         s3_sh_ff    <= s2_sh_ff;
         s3_last_ff  <= s2_last_ff;
         s3_flag_ff  <= s2_flag_ff;

         rsp_grad_ff <= rsp_grad_in;
         rsp_last_ff <= s3_last_ff;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.grad_out    = rsp_grad_ff;
   assign rsp_ch.result_last = rsp_last_ff;
   assign rsp_ch.saturated   = rsp_sat_ff;

   a_row_index: assert property (@(posedge clock) disable iff (reset)
      issue_state_ff == ISSUE_ROW |->
         (row_count_ff != '0 && CNT_W'(elem_idx_ff) < row_count_ff))
      else $error("row element index outside buffered row");

   a_row_end: assert property (@(posedge clock) disable iff (reset)
      row_done |=> issue_state_ff == ISSUE_CMD)
      else $error("sequencer stayed in row drain after last element");

endmodule

@@ design/activation_gradient_unit_core.sv @@
// ============================================================================
// activation_gradient_unit_core - backward pass of a neural activation
// Top level: front end, command queue, row buffer RAM and back-end pipeline.
// ============================================================================
// Timing: in linear, logistic, tanh, relu and leaky relu modes one pair is
// taken per clock while the command queue has room. Its result passes the
// issue, operand, multiply, recombine and output registers in turn, one
// result per clock sustained while rsp_ch.ready is high. In softmax mode each
// element is stored in the row buffer as it is taken. After the row_last
// element the row is replayed from the row buffer at one result per clock
// while the output is not stalled, once the row command has left the queue.
// Softmax input is held off from the row_last transfer until the last
// element of that row has been read out of the row buffer, since the buffer
// holds a single row.
// ============================================================================
module activation_gradient_unit_core import agu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   agu_req_if.sink    req_ch,
   agu_rsp_if.source  rsp_ch,
   agu_csr_if.sink    csr_ch
);

   // front end -> queue
   logic               fifo_push;
   cmd_type            fifo_din;
   logic               fifo_full;

   // queue -> back end
   logic               fifo_pop;
   cmd_type            fifo_dout;
   logic               fifo_empty;

   // row buffer ports: {out_value, grad_in} per element
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [RAM_W-1:0]   ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [RAM_W-1:0]   ram_rd_data;

   // back end tells the front end the row buffer is free again
   logic               row_done;
   logic [SLOPE_W-1:0] leak_slope;

   // Intake, register file and softmax accumulation
   agu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_ch      (csr_ch),
      .fifo_full   (fifo_full),
      .fifo_push   (fifo_push),
      .fifo_din    (fifo_din),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .row_done    (row_done),
      .leak_slope  (leak_slope)
   );

   // Decouples intake from the result pipeline
   agu_cmd_fifo u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (fifo_push),
      .din   (fifo_din),
      .pop   (fifo_pop),
      .dout  (fifo_dout),
      .full  (fifo_full),
      .empty (fifo_empty)
   );

   // Softmax row buffer; entries past the current row are never read
   agu_ram #(
      .DEPTH (MAX_ROW),
      .WIDTH (RAM_W)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Derivative arithmetic and response register
   agu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_empty  (fifo_empty),
      .fifo_dout   (fifo_dout),
      .fifo_pop    (fifo_pop),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .row_done    (row_done),
      .leak_slope  (leak_slope),
      .rsp_ch      (rsp_ch)
   );

endmodule
